### rtl/mrm_pkg.sv
// Shared types and constants for the 4x4 matrix row multiply unit.
// Used by mrm_bmat, mrm_lane and matrix4_row_multiply_unit; depends on nothing.
`default_nettype none

package mrm_pkg;

    // Matrix shape and number format.
    localparam int MATRIX_DIM = 4;
    localparam int FRAC_BITS  = 16;
    localparam int NUM_COLS   = 4;
    localparam int WORD_W     = 32;
    localparam int PROD_W     = 2 * WORD_W;
    localparam int ACC_W      = PROD_W + $clog2(MATRIX_DIM);
    localparam int LANES      = (MATRIX_DIM < NUM_COLS) ? MATRIX_DIM : NUM_COLS;

    // Stream layout.
    localparam int IN_DATA_W  = (NUM_COLS + 1) * WORD_W;
    localparam int IN_USER_W  = 5;
    localparam int OUT_DATA_W = NUM_COLS * WORD_W;

    localparam logic [WORD_W-1:0] FIX_ONE  = WORD_W'(1) << FRAC_BITS;
    localparam logic [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    // Operation codes carried in the request.
    localparam logic [2:0] MODE_LOAD  = 3'd0;
    localparam logic [2:0] MODE_MUL   = 3'd1;
    localparam logic [2:0] MODE_ADD   = 3'd2;
    localparam logic [2:0] MODE_SUB   = 3'd3;
    localparam logic [2:0] MODE_SCALE = 3'd4;

    typedef logic [WORD_W-1:0] word_t;
    typedef word_t [MATRIX_DIM-1:0] row_t;
    typedef row_t [MATRIX_DIM-1:0] bmat_t;

    // Load strobes for the three lane pipeline stages.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } stage_en_t;

    // Operands handed to one column lane.
    typedef struct packed {
        logic [2:0] mode;
        row_t       row;
        row_t       mult_b;
        word_t      as_a;
        word_t      as_b;
    } lane_in_t;

endpackage

`default_nettype wire

### rtl/mrm_bmat.sv
// Register file holding the right-hand matrix B, reset to the identity.
// Depends on mrm_pkg for the matrix shape and word types.
`default_nettype none

module mrm_bmat
    import mrm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       wr_en,
    input  wire logic [1:0] wr_row,
    input  wire row_t       wr_data,
    output bmat_t           bmat
);

    bmat_t bmat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MATRIX_DIM; i++)
            begin
                for (int j = 0; j < MATRIX_DIM; j++)
                begin
                    bmat_reg[i][j] <= (i == j) ? FIX_ONE : '0;
                end
            end
        end
        else if (wr_en)
        begin
            // A row number beyond the matrix matches no row and is dropped.
            for (int i = 0; i < MATRIX_DIM; i++)
            begin
                if (int'(wr_row) == i)
                begin
                    bmat_reg[i] <= wr_data;
                end
            end
        end
    end

    assign bmat = bmat_reg;

endmodule

`default_nettype wire

### rtl/mrm_lane.sv
// One column lane: multipliers, sum of products, floor shift and saturation.
// Depends on mrm_pkg; three registered stages, the last one feeds the output.
`default_nettype none

module mrm_lane
    import mrm_pkg::*;
(
    input  wire logic      clk,
    input  wire stage_en_t en,
    input  wire lane_in_t  din,
    output word_t          res,
    output logic           sat
);

    logic signed [WORD_W:0]   sa;
    logic signed [WORD_W:0]   sb;
    logic signed [WORD_W:0]   as_sum;
    logic signed [PROD_W-1:0] as_ext;
    logic signed [PROD_W-1:0] mul      [MATRIX_DIM];
    logic signed [PROD_W-1:0] prod_next[MATRIX_DIM];
    logic signed [PROD_W-1:0] prod_reg [MATRIX_DIM];
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  shifted;
    logic                     fits;
    word_t                    res_next;
    word_t                    res_reg;
    logic                     sat_reg;
    logic                     is_addsub;

    // Stage 1: products, or the exact add/subtract result scaled up so that
    // the common floor shift in stage 3 returns it unchanged.
    assign sa        = $signed({din.as_a[WORD_W-1], din.as_a});
    assign sb        = $signed({din.as_b[WORD_W-1], din.as_b});
    assign as_sum    = (din.mode == MODE_SUB) ? (sa - sb) : (sa + sb);
    assign as_ext    = PROD_W'(as_sum) <<< FRAC_BITS;
    assign is_addsub = (din.mode == MODE_ADD) || (din.mode == MODE_SUB);

    for (genvar k = 0; k < MATRIX_DIM; k++)
    begin : g_mul
        assign mul[k] = $signed(din.row[k]) * $signed(din.mult_b[k]);
        if (k == 0)
        begin : g_first
            assign prod_next[k] = is_addsub ? as_ext : mul[k];
        end
        else
        begin : g_rest
            assign prod_next[k] = is_addsub ? PROD_W'(0) : mul[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            prod_reg <= prod_next;
        end
    end

    // Stage 2: exact sum of the products.
    always_comb
    begin
        acc_next = '0;
        for (int k = 0; k < MATRIX_DIM; k++)
        begin
            acc_next = acc_next + ACC_W'(prod_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            acc_reg <= acc_next;
        end
    end

    // Stage 3: arithmetic shift (floor) and clamp to a signed word.
    assign shifted  = acc_reg >>> FRAC_BITS;
    assign fits     = (&shifted[ACC_W-1:WORD_W-1]) || !(|shifted[ACC_W-1:WORD_W-1]);
    assign res_next = fits ? shifted[WORD_W-1:0]
                           : (shifted[ACC_W-1] ? WORD_MIN : WORD_MAX);

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            res_reg <= res_next;
            sat_reg <= !fits;
        end
    end

    assign res = res_reg;
    assign sat = sat_reg;

endmodule

`default_nettype wire

### rtl/matrix4_row_multiply_unit.sv
// Top level of the 4x4 matrix row multiply unit.
// Depends on mrm_pkg, mrm_bmat and mrm_lane.
//
// Usage: requests arrive on the s_axis channel, one row per request, and
// results leave on the m_axis channel. A request carries a mode and a row
// number in tuser and four Q16.16 elements plus a scalar in tdata. A load
// request writes the row into matrix B at the accepting edge and gives no
// result; so do the unused modes 5 to 7, which change nothing. Multiply,
// add, subtract and scale requests each give exactly one result row with a
// saturation flag in tuser.
// The products register at the accepting edge, then the sum and then the
// shifted, clamped word, across four column lanes. Throughput: one request
// per cycle while the output is not stalled, set by the one-row-per-cycle
// lanes; a load may be followed at once by a multiply that uses the new row.
// When the receiver stalls, each stage keeps filling as long as the stage
// after it is empty or moving, so up to three results queue in the pipeline
// before s_axis_tready falls. Reset empties the pipeline and restores B to
// the identity matrix.
`default_nettype none

module matrix4_row_multiply_unit
    import mrm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // Fields from bit 0: elem0, elem1, elem2, elem3, scalar (32 bits each).
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // Fields from bit 0: mode (3 bits), row_index (2 bits).
    input  wire logic [IN_USER_W-1:0]  s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // Fields from bit 0: out0, out1, out2, out3 (32 bits each).
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    // Fields from bit 0: saturated (1 bit).
    output logic [0:0]                 m_axis_tuser
);

    logic [2:0]  mode;
    logic [1:0]  row_index;
    word_t       scalar;
    row_t        row;
    bmat_t       bmat;
    logic        accept;
    logic        is_compute;
    logic        row_in_range;
    logic        rdy1;
    logic        rdy2;
    logic        rdy3;
    logic        v1_reg;
    logic        v2_reg;
    logic        vout_reg;
    stage_en_t   en;
    lane_in_t    lane_in [LANES];
    word_t       lane_res[LANES];
    logic [LANES-1:0] lane_sat;

    // Request unpacking; input columns beyond the fourth read as zero.
    assign mode      = s_axis_tuser[2:0];
    assign row_index = s_axis_tuser[4:3];
    assign scalar    = s_axis_tdata[NUM_COLS*WORD_W +: WORD_W];

    for (genvar k = 0; k < MATRIX_DIM; k++)
    begin : g_row
        if (k < NUM_COLS)
        begin : g_col
            assign row[k] = s_axis_tdata[k*WORD_W +: WORD_W];
        end
        else
        begin : g_pad
            assign row[k] = '0;
        end
    end

    assign is_compute   = (mode == MODE_MUL) || (mode == MODE_ADD) ||
                          (mode == MODE_SUB) || (mode == MODE_SCALE);
    assign row_in_range = int'(row_index) < MATRIX_DIM;

    // Ready chain: a stage may load when it is empty or drains this cycle.
    assign rdy3          = !vout_reg || m_axis_tready;
    assign rdy2          = !v2_reg || rdy3;
    assign rdy1          = !v1_reg || rdy2;
    assign s_axis_tready = rdy1;
    assign accept        = s_axis_tvalid && rdy1;

    assign en.s1 = accept && is_compute;
    assign en.s2 = v1_reg && rdy2;
    assign en.s3 = v2_reg && rdy3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            vout_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= accept && is_compute;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                vout_reg <= v2_reg;
            end
        end
    end

    // Matrix B is written at the accepting edge of a load request, so the
    // next request already reads the new row.
    mrm_bmat u_bmat (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept && (mode == MODE_LOAD) && row_in_range),
        .wr_row  (row_index),
        .wr_data (row),
        .bmat    (bmat)
    );

    // Operand selection per lane. For scaling, only the multiplier on the
    // lane's own column sees the scalar, so the sum is row[c] * scalar.
    for (genvar c = 0; c < LANES; c++)
    begin : g_lane
        always_comb
        begin
            lane_in[c].mode = mode;
            lane_in[c].row  = row;
            lane_in[c].as_a = row[c];
            lane_in[c].as_b = '0;
            for (int i = 0; i < MATRIX_DIM; i++)
            begin
                if (int'(row_index) == i)
                begin
                    lane_in[c].as_b = bmat[i][c];
                end
            end
            for (int k = 0; k < MATRIX_DIM; k++)
            begin
                if (mode == MODE_SCALE)
                begin
                    lane_in[c].mult_b[k] = (k == c) ? scalar : '0;
                end
                else
                begin
                    lane_in[c].mult_b[k] = bmat[k][c];
                end
            end
        end

        mrm_lane u_lane (
            .clk (clk),
            .en  (en),
            .din (lane_in[c]),
            .res (lane_res[c]),
            .sat (lane_sat[c])
        );
    end

    // Merge: pack the lane results and combine their saturation flags.
    for (genvar c = 0; c < NUM_COLS; c++)
    begin : g_out
        if (c < LANES)
        begin : g_used
            assign m_axis_tdata[c*WORD_W +: WORD_W] = lane_res[c];
        end
        else
        begin : g_zero
            assign m_axis_tdata[c*WORD_W +: WORD_W] = '0;
        end
    end

    assign m_axis_tvalid   = vout_reg;
    assign m_axis_tuser[0] = |lane_sat;

endmodule

`default_nettype wire

### bench/matrix4_row_multiply_unit_test.sv
// Self-checking bench for matrix4_row_multiply_unit: a directed table, then random rows
// with bursty requests and a stalling receiver. Depends on mrm_pkg and the unit itself.
`default_nettype none

module matrix4_row_multiply_unit_test;
    import mrm_pkg::*;

    // Modes that the unit must ignore.
    localparam logic [2:0] MODE_SPARE5 = 3'd5;
    localparam logic [2:0] MODE_SPARE6 = 3'd6;
    localparam logic [2:0] MODE_SPARE7 = 3'd7;

    // Receiver behaviors, switched every so often.
    localparam int SINK_FREE     = 0;
    localparam int SINK_MOSTLY   = 1;
    localparam int SINK_SPARSE   = 2;
    localparam int SINK_PERIODIC = 3;

    localparam int RANDOM_ROWS  = 1530;
    localparam int NUM_DIRECTED = 22;
    localparam int REPORT_LIMIT = 10;

    localparam logic signed [127:0] ACC_HI = 128'sd2147483647;
    localparam logic signed [127:0] ACC_LO = -128'sd2147483648;

    typedef struct packed {
        row_t col;
        logic sat;
    } row_result_t;

    // One directed request; the want fields are used only when pinned is set.
    typedef struct {
        logic [2:0] op;
        logic [1:0] ridx;
        word_t      e0, e1, e2, e3, scal;
        bit         pinned;
        word_t      w0, w1, w2, w3;
        bit         wsat;
    } row_request_t;

    logic                  clk;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [0:0]            m_axis_tuser;

    // Our own copy of matrix B, updated in request order.
    bmat_t       shadow_b;
    row_result_t expected_rows [$];
    int          fail_count = 0;
    int          burst_left = 0;
    int          sink_cycle = 0;
    int          sink_style = SINK_FREE;

    // Typed-in expectation that travels with the request on the bus.
    logic        pin_now    = 1'b0;
    row_result_t pin_result = '0;

    // Rows marked pinned carry an answer that follows directly from an identity B,
    // a clamp, or the floor of a tiny scale product.
    row_request_t dir_table [NUM_DIRECTED] = '{
        '{MODE_MUL, 2'd0, 32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000, 32'h7FFF_FFFF,
          32'hDEAD_BEEF, 1'b1, 32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000, 32'h7FFF_FFFF, 1'b0},
        '{MODE_MUL, 2'd3, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_8000,
          32'h0, 1'b1, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_8000, 1'b0},
        '{MODE_ADD, 2'd0, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0,
          32'h0, 1'b1, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 1'b1},
        '{MODE_SUB, 2'd1, 32'h0, 32'h8000_0000, 32'h0, 32'h0,
          32'h0, 1'b1, 32'h0, 32'h8000_0000, 32'h0, 32'h0, 1'b1},
        '{MODE_ADD, 2'd2, 32'hFFFF_0000, 32'h0, 32'h0, 32'h0,
          32'h7FFF_FFFF, 1'b1, 32'hFFFF_0000, 32'h0, 32'h0001_0000, 32'h0, 1'b0},
        '{MODE_SUB, 2'd3, 32'h0, 32'h0, 32'h0, 32'h0,
          32'h0, 1'b1, 32'h0, 32'h0, 32'h0, 32'hFFFF_0000, 1'b0},
        '{MODE_SCALE, 2'd0, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, 32'h8000_0000,
          32'h0001_0000, 1'b1, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0},
        '{MODE_SCALE, 2'd1, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_8000, 32'hFFFF_8000,
          32'h0000_0001, 1'b1, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 1'b0},
        '{MODE_SCALE, 2'd2, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
          32'h8000_0000, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1},
        '{MODE_SCALE, 2'd3, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
          32'h8000_0000, 1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1},
        // Unused modes must produce nothing and leave B alone.
        '{MODE_SPARE5, 2'd0, 32'h1234_5678, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000,
          32'h5555_AAAA, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
        '{MODE_SPARE6, 2'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
          32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
        '{MODE_SPARE7, 2'd3, 32'hAAAA_5555, 32'h0, 32'h7FFF_FFFF, 32'h0001_0000,
          32'h0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
        // A load followed at once by requests that use the new row.
        '{MODE_LOAD, 2'd2, 32'h0002_0000, 32'hFFFF_8000, 32'h7FFF_FFFF, 32'h8000_0000,
          32'h0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
        '{MODE_MUL, 2'd0, 32'h0, 32'h0, 32'h0001_0000, 32'h0,
          32'h0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
        '{MODE_ADD, 2'd2, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h8000_0000,
          32'h7FFF_FFFF, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
        '{MODE_LOAD, 2'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
          32'h0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
        '{MODE_LOAD, 2'd1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
          32'h0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
        '{MODE_LOAD, 2'd3, 32'h0000_8000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0,
          32'h0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
        '{MODE_MUL, 2'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'hFFFF_0000,
          32'h0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
        '{MODE_MUL, 2'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
          32'h0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
        '{MODE_SUB, 2'd1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
          32'h0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0}
    };

    matrix4_row_multiply_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Applies one request to the shadow of B and computes its result row, if any.
    function automatic bit predict_row_op(input logic [2:0] op, input logic [1:0] ridx,
                                          input row_t vec, input word_t scal,
                                          output row_result_t res);
        logic signed [127:0] acc;
        logic signed [127:0] lhs;
        logic signed [127:0] rhs;
        int c;
        int k;
        res = '0;
        if (op == MODE_LOAD)
        begin
            shadow_b[ridx] = vec;
            return 1'b0;
        end
        if (op > MODE_SCALE)
            return 1'b0;
        for (c = 0; c < MATRIX_DIM; c++)
        begin
            acc = '0;
            case (op)
                MODE_MUL:
                begin
                    // Exact sum of the four products, then an arithmetic shift (floor).
                    for (k = 0; k < MATRIX_DIM; k++)
                    begin
                        lhs = signed'(vec[k]);
                        rhs = signed'(shadow_b[k][c]);
                        acc += lhs * rhs;
                    end
                    acc = acc >>> FRAC_BITS;
                end
                MODE_SCALE:
                begin
                    lhs = signed'(vec[c]);
                    rhs = signed'(scal);
                    acc = (lhs * rhs) >>> FRAC_BITS;
                end
                MODE_ADD:
                begin
                    lhs = signed'(vec[c]);
                    rhs = signed'(shadow_b[ridx][c]);
                    acc = lhs + rhs;
                end
                default:
                begin
                    lhs = signed'(vec[c]);
                    rhs = signed'(shadow_b[ridx][c]);
                    acc = lhs - rhs;
                end
            endcase
            if (acc > ACC_HI)
            begin
                res.col[c] = WORD_MAX;
                res.sat    = 1'b1;
            end
            else if (acc < ACC_LO)
            begin
                res.col[c] = WORD_MIN;
                res.sat    = 1'b1;
            end
            else
                res.col[c] = acc[WORD_W-1:0];
        end
        return 1'b1;
    endfunction

    // Mostly small Q16.16 values so products stay in range, plus raw words and extremes.
    function automatic word_t random_word();
        word_t w;
        bit    shrink;
        shrink = 1'b1;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: w = word_t'($urandom_range(0, 32'h0004_0000));
            4, 5, 6:
            begin
                w      = $urandom;
                shrink = 1'b0;
            end
            7:
            begin
                shrink = 1'b0;
                case ($urandom_range(0, 5))
                    0:       w = WORD_MAX;
                    1:       w = WORD_MIN;
                    2:       w = FIX_ONE;
                    3:       w = -FIX_ONE;
                    4:       w = '1;
                    default: w = '0;
                endcase
            end
            default: w = word_t'($urandom_range(0, 32'h0000_FFFF));
        endcase
        if (shrink && $urandom_range(0, 1) == 1)
            w = -w;
        return w;
    endfunction

    function automatic row_request_t random_request();
        row_request_t r;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 20)
            r.op = MODE_LOAD;
        else if (pick < 50)
            r.op = MODE_MUL;
        else if (pick < 62)
            r.op = MODE_ADD;
        else if (pick < 74)
            r.op = MODE_SUB;
        else if (pick < 94)
            r.op = MODE_SCALE;
        else
            r.op = 3'($urandom_range(MODE_SPARE5, MODE_SPARE7));
        r.ridx   = 2'($urandom_range(0, 3));
        r.e0     = random_word();
        r.e1     = random_word();
        r.e2     = random_word();
        r.e3     = random_word();
        r.scal   = random_word();
        r.pinned = 1'b0;
        r.w0     = '0;
        r.w1     = '0;
        r.w2     = '0;
        r.w3     = '0;
        r.wsat   = 1'b0;
        return r;
    endfunction

    // Presents one request, waits for the handshake, then maybe opens a gap.
    task automatic send_request(input row_request_t r);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= {r.ridx, r.op};
        s_axis_tdata  <= {r.scal, r.e3, r.e2, r.e1, r.e0};
        pin_now       <= r.pinned;
        pin_result    <= '{col: {r.w3, r.w2, r.w1, r.w0}, sat: r.wsat};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            case ($urandom_range(0, 7))
                0, 1, 2: gap = 0;
                7:       gap = $urandom_range(10, 30);
                default: gap = $urandom_range(1, 5);
            endcase
            if (gap > 0)
            begin
                // Idle bus carries junk that must not be taken.
                s_axis_tvalid <= 1'b0;
                s_axis_tuser  <= IN_USER_W'($urandom);
                s_axis_tdata  <= {$urandom, $urandom, $urandom, $urandom, $urandom};
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    task automatic note_failure(input string what);
        if (fail_count < REPORT_LIMIT)
            $display("mismatch at %0t: %s", $time, what);
        fail_count++;
    endtask

    // Receiver: ready pattern switches among the sink styles at random.
    always @(posedge clk)
    begin
        sink_cycle <= sink_cycle + 1;
        if (sink_cycle % 97 == 0)
            sink_style <= $urandom_range(SINK_FREE, SINK_PERIODIC);
        case (sink_style)
            SINK_FREE:   m_axis_tready <= 1'b1;
            SINK_MOSTLY: m_axis_tready <= ($urandom_range(0, 3) != 0);
            SINK_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default:     m_axis_tready <= (sink_cycle % 16 < 4);
        endcase
    end

    // Both handshakes are sampled at the edge, before any update lands.
    always @(posedge clk)
    begin
        row_result_t predicted;
        row_result_t got;
        row_result_t want;
        bit          yields;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                yields = predict_row_op(s_axis_tuser[2:0], s_axis_tuser[4:3],
                                        s_axis_tdata[OUT_DATA_W-1:0],
                                        s_axis_tdata[IN_DATA_W-1 -: WORD_W], predicted);
                if (yields)
                    expected_rows.push_back(pin_now ? pin_result : predicted);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.col = m_axis_tdata;
                got.sat = m_axis_tuser[0];
                if (expected_rows.size() == 0)
                    note_failure($sformatf("unexpected result %h sat %b", got.col, got.sat));
                else
                begin
                    want = expected_rows.pop_front();
                    for (int c = 0; c < MATRIX_DIM; c++)
                        if (got.col[c] !== want.col[c])
                            note_failure($sformatf("out%0d expected %h got %h",
                                                   c, want.col[c], got.col[c]));
                    if (got.sat !== want.sat)
                        note_failure($sformatf("saturated expected %b got %b",
                                               want.sat, got.sat));
                end
            end
        end
    end

    initial
    begin
        row_request_t req;
        for (int i = 0; i < MATRIX_DIM; i++)
            for (int j = 0; j < MATRIX_DIM; j++)
                shadow_b[i][j] = (i == j) ? FIX_ONE : '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        foreach (dir_table[i])
            send_request(dir_table[i]);
        for (int n = 0; n < RANDOM_ROWS; n++)
        begin
            req = random_request();
            send_request(req);
        end
        s_axis_tvalid <= 1'b0;
        // Let the last accepted request reach the queue before waiting for it to drain.
        @(posedge clk);
        while (expected_rows.size() != 0)
            @(posedge clk);
        // Three pipeline stages; the extra wait catches any stray result.
        repeat (8) @(posedge clk);
        if (fail_count == 0 && expected_rows.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
